@@ src/urs_pkg.sv @@
// Shared types and constants for the bounded undo/redo history block.
package urs_pkg;

	localparam int MAX_DEPTH  = 32;
	localparam int WORD_WIDTH = 32;
	localparam int IDX_W      = $clog2(MAX_DEPTH);
	localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
	localparam int CAP_W      = 6;
	localparam int OP_W       = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_UNDO  = 2'd1;
	localparam logic [OP_W-1:0] OP_REDO  = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// One access to a history store: an optional write and an optional read.
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		logic  re;
		idx_t  raddr;
	} mem_cmd_t;

	// Status of one request, before the result register.
	typedef struct packed {
		logic ok;
		logic from_undo;
		logic from_redo;
		cnt_t undo_count;
		cnt_t redo_count;
	} resp_t;

endpackage

@@ src/urs_ram.sv @@
// Single-port-write, single-port-read store with registered read data.
module urs_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/urs_ctrl.sv @@
// Pointer and depth control for the undo ring and the redo stack.
module urs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [urs_pkg::OP_W-1:0] opcode,
	input  urs_pkg::word_t          snapshot_in,
	input  logic [urs_pkg::CAP_W-1:0] capacity,
	output urs_pkg::mem_cmd_t       undo_cmd,
	output urs_pkg::mem_cmd_t       redo_cmd,
	output urs_pkg::resp_t          resp
);
	import urs_pkg::*;

	idx_t oldest_q;
	cnt_t undo_depth_q;
	cnt_t redo_depth_q;

	idx_t oldest_n;
	cnt_t undo_depth_n;
	cnt_t redo_depth_n;

	cnt_t eff_cap;
	idx_t app_slot;
	idx_t app_oldest;
	cnt_t app_depth;
	cnt_t drop;
	cnt_t undo_top;
	cnt_t redo_top;

	// Capacity clamped to the range one to the store depth.
	always_comb begin
		if (capacity == '0) begin
			eff_cap = cnt_t'(1);
		end else if (capacity > CAP_W'(MAX_DEPTH)) begin
			eff_cap = cnt_t'(MAX_DEPTH);
		end else begin
			eff_cap = cnt_t'(capacity);
		end
	end

	// Append to the undo ring; a full ring overwrites its oldest slot.
	always_comb begin
		if (undo_depth_q == cnt_t'(MAX_DEPTH)) begin
			app_slot   = oldest_q;
			app_oldest = oldest_q + idx_t'(1);
			app_depth  = cnt_t'(MAX_DEPTH);
		end else begin
			app_slot   = oldest_q + undo_depth_q[IDX_W-1:0];
			app_oldest = oldest_q;
			app_depth  = undo_depth_q + cnt_t'(1);
		end
		drop     = app_depth - eff_cap;
		undo_top = undo_depth_q - cnt_t'(1);
		redo_top = redo_depth_q - cnt_t'(1);
	end

	// Next state, store accesses and status for the request.
	always_comb begin
		oldest_n       = oldest_q;
		undo_depth_n   = undo_depth_q;
		redo_depth_n   = redo_depth_q;
		undo_cmd       = '0;
		redo_cmd       = '0;
		undo_cmd.wdata = snapshot_in;
		redo_cmd.wdata = snapshot_in;
		resp           = '0;
		resp.ok        = 1'b1;
		unique case (opcode)
			OP_PUSH: begin
				undo_cmd.we    = 1'b1;
				undo_cmd.waddr = app_slot;
				redo_depth_n   = '0;
				if (app_depth > eff_cap) begin
					oldest_n     = app_oldest + drop[IDX_W-1:0];
					undo_depth_n = eff_cap;
				end else begin
					oldest_n     = app_oldest;
					undo_depth_n = app_depth;
				end
			end
			OP_UNDO: begin
				if (undo_depth_q == '0) begin
					resp.ok = 1'b0;
				end else begin
					redo_cmd.we    = 1'b1;
					redo_cmd.waddr = redo_depth_q[IDX_W-1:0];
					redo_depth_n   = redo_depth_q + cnt_t'(1);
					undo_cmd.re    = 1'b1;
					undo_cmd.raddr = oldest_q + undo_top[IDX_W-1:0];
					undo_depth_n   = undo_top;
					resp.from_undo = 1'b1;
				end
			end
			OP_REDO: begin
				if (redo_depth_q == '0) begin
					resp.ok = 1'b0;
				end else begin
					redo_cmd.re    = 1'b1;
					redo_cmd.raddr = redo_top[IDX_W-1:0];
					redo_depth_n   = redo_top;
					undo_cmd.we    = 1'b1;
					undo_cmd.waddr = app_slot;
					oldest_n       = app_oldest;
					undo_depth_n   = app_depth;
					resp.from_redo = 1'b1;
				end
			end
			OP_CLEAR: begin
				undo_depth_n = '0;
				redo_depth_n = '0;
			end
			default: begin
				resp.ok = 1'b0;
			end
		endcase
		resp.undo_count = undo_depth_n;
		resp.redo_count = redo_depth_n;
		if (!accept) begin
			undo_cmd.we = 1'b0;
			undo_cmd.re = 1'b0;
			redo_cmd.we = 1'b0;
			redo_cmd.re = 1'b0;
		end
	end

	// History pointers and depths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q     <= '0;
			undo_depth_q <= '0;
			redo_depth_q <= '0;
		end else if (accept) begin
			oldest_q     <= oldest_n;
			undo_depth_q <= undo_depth_n;
			redo_depth_q <= redo_depth_n;
		end
	end

endmodule

@@ src/bounded_undo_redo_stacks_top.sv @@
// Top level of the bounded undo/redo history block.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. busy never rises, so a request may be issued in every cycle. Each
// request carries an opcode (push, undo, redo, clear) and a snapshot word.
// Exactly one result follows per request: done is high for one cycle, in the
// cycle after the accepting edge, with success, snapshot_out and both stack
// depths. Throughput is one request per cycle. Each history store has a
// registered read port that returns the popped word at the same edge as
// the pointer update. The receiver cannot stall, so results are never held
// back. The user must write history_capacity through cfg_we/cfg_data only
// while no request is in flight; the block does not enforce this. Values
// above the store depth act as the depth, zero acts as one. Reset clears
// both depths, the ring pointer and done, and sets the capacity to twenty.
// Store contents are not cleared; only live entries are read.
module bounded_undo_redo_stacks_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [urs_pkg::OP_W-1:0]  opcode,
	input  urs_pkg::word_t            snapshot_in,
	input  logic                      cfg_we,
	input  logic [urs_pkg::CAP_W-1:0] cfg_data,
	output logic                      done,
	output logic                      success,
	output urs_pkg::word_t            snapshot_out,
	output urs_pkg::cnt_t             undo_count,
	output urs_pkg::cnt_t             redo_count
);
	import urs_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             accept;
	mem_cmd_t         undo_cmd;
	mem_cmd_t         redo_cmd;
	resp_t            resp;
	resp_t            resp_s1;
	logic             done_s1;
	word_t            undo_rdata;
	word_t            redo_rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	urs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (opcode),
		.snapshot_in (snapshot_in),
		.capacity    (capacity_q),
		.undo_cmd    (undo_cmd),
		.redo_cmd    (redo_cmd),
		.resp        (resp)
	);

	urs_ram #(
		.DEPTH (MAX_DEPTH),
		.WIDTH (WORD_WIDTH)
	) u_undo_ram (
		.clk   (clk),
		.we    (undo_cmd.we),
		.waddr (undo_cmd.waddr),
		.wdata (undo_cmd.wdata),
		.re    (undo_cmd.re),
		.raddr (undo_cmd.raddr),
		.rdata (undo_rdata)
	);

	urs_ram #(
		.DEPTH (MAX_DEPTH),
		.WIDTH (WORD_WIDTH)
	) u_redo_ram (
		.clk   (clk),
		.we    (redo_cmd.we),
		.waddr (redo_cmd.waddr),
		.wdata (redo_cmd.wdata),
		.re    (redo_cmd.re),
		.raddr (redo_cmd.raddr),
		.rdata (redo_rdata)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Result status, aligned with the store read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1 <= resp;
		end
	end

	// Pick the popped word from the store that was read.
	always_comb begin
		priority if (resp_s1.from_undo) begin
			snapshot_out = undo_rdata;
		end else if (resp_s1.from_redo) begin
			snapshot_out = redo_rdata;
		end else begin
			snapshot_out = '0;
		end
	end

	assign done       = done_s1;
	assign success    = resp_s1.ok;
	assign undo_count = resp_s1.undo_count;
	assign redo_count = resp_s1.redo_count;

endmodule

@@ tb/bounded_undo_redo_stacks_top_tb.sv @@
// Self-checking testbench for the bounded undo/redo history block.
module bounded_undo_redo_stacks_top_tb;

	import urs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 100;

	// One expected result of a request.
	typedef struct {
		logic  ok;
		word_t word;
		cnt_t  undo_cnt;
		cnt_t  redo_cnt;
	} step_result_t;

	// Tracks the undo ring and the redo stack and predicts each result in order.
	class undo_history_tracker;
		word_t              undo_ring[MAX_DEPTH];
		idx_t               oldest;
		int                 undo_depth;
		word_t              redo_stack[MAX_DEPTH];
		int                 redo_depth;
		logic [CAP_W-1:0]   capacity;
		step_result_t       expected_q[$];
		int                 errors;

		function new();
			oldest     = '0;
			undo_depth = 0;
			redo_depth = 0;
			capacity   = CAP_RESET;
			errors     = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void drop_oldest_undo();
			if (undo_depth > 0) begin
				oldest = idx_t'(oldest + 1);
				undo_depth--;
			end
		endfunction

		// The undo store is a ring; a full ring loses its oldest entry first.
		function void undo_append(word_t w);
			if (undo_depth >= MAX_DEPTH)
				drop_oldest_undo();
			undo_ring[idx_t'(oldest + undo_depth)] = w;
			undo_depth++;
		endfunction

		// The redo store is a plain stack; a full one shifts out its bottom entry.
		function void redo_append(word_t w);
			if (redo_depth >= MAX_DEPTH) begin
				for (int i = 0; i < MAX_DEPTH - 1; i++)
					redo_stack[i] = redo_stack[i + 1];
				redo_depth--;
			end
			redo_stack[redo_depth] = w;
			redo_depth++;
		endfunction

		// Applies one accepted request and queues the result it must produce.
		function void note_request(logic [OP_W-1:0] op, word_t w);
			step_result_t r;
			int           keep;
			r.ok   = 1'b1;
			r.word = '0;
			case (op)
				OP_PUSH: begin
					undo_append(w);
					redo_depth = 0;
					// Zero acts as one and anything above the store depth as the depth.
					if (capacity == 0)
						keep = 1;
					else if (capacity > MAX_DEPTH)
						keep = MAX_DEPTH;
					else
						keep = capacity;
					while (undo_depth > keep)
						drop_oldest_undo();
				end
				OP_UNDO: begin
					if (undo_depth == 0) begin
						r.ok = 1'b0;
					end else begin
						redo_append(w);
						undo_depth--;
						r.word = undo_ring[idx_t'(oldest + undo_depth)];
					end
				end
				OP_REDO: begin
					if (redo_depth == 0) begin
						r.ok = 1'b0;
					end else begin
						redo_depth--;
						r.word = redo_stack[redo_depth];
						undo_append(w);
					end
				end
				default: begin
					undo_depth = 0;
					redo_depth = 0;
				end
			endcase
			r.undo_cnt = cnt_t'(undo_depth);
			r.redo_cnt = cnt_t'(redo_depth);
			expected_q.push_back(r);
		endfunction

		function void check_field(string name, logic [WORD_WIDTH-1:0] want,
				logic [WORD_WIDTH-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compares one result with the oldest outstanding prediction.
		function void check_result(logic ok, word_t w, cnt_t u_cnt, cnt_t r_cnt);
			step_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			check_field("success", e.ok, ok);
			check_field("snapshot_out", e.word, w);
			check_field("undo_count", e.undo_cnt, u_cnt);
			check_field("redo_count", e.redo_cnt, r_cnt);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [OP_W-1:0]   opcode;
	word_t             snapshot_in;
	logic              cfg_we;
	logic [CAP_W-1:0]  cfg_data;
	logic              done;
	logic              success;
	word_t             snapshot_out;
	cnt_t              undo_count;
	cnt_t              redo_count;

	undo_history_tracker tracker;
	bit                  idling;
	int                  cycles;

	bounded_undo_redo_stacks_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.snapshot_in  (snapshot_in),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.done         (done),
		.success      (success),
		.snapshot_out (snapshot_out),
		.undo_count   (undo_count),
		.redo_count   (redo_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Results are checked before the request accepted at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(success, snapshot_out, undo_count, redo_count);
			if (start && !busy)
				tracker.note_request(opcode, snapshot_in);
		end
	end

	// Mostly back-to-back requests, some short gaps and a few long ones.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (!idling || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Presents one request and holds it until it is accepted.
	task automatic issue(logic [OP_W-1:0] op, word_t w);
		int gap;
		start       <= 1'b1;
		opcode      <= op;
		snapshot_in <= w;
		do
			@(posedge clk);
		while (busy);
		gap = gap_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops issuing and waits until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		tracker.set_capacity(value);
	endtask

	// Random bursts: push runs fill the ring, undo and redo runs walk back and
	// forth through the history and run into empty stacks, plus mixed noise.
	task automatic run_bursts(int n_items);
		int               issued;
		int               mode;
		int               len;
		logic [OP_W-1:0]  op;
		issued = 0;
		while (issued < n_items) begin
			mode = $urandom_range(0, 9);
			if (mode <= 3) begin
				len = $urandom_range(1, 40);
				op  = OP_PUSH;
			end else if (mode <= 5) begin
				len = $urandom_range(1, 12);
				op  = OP_UNDO;
			end else if (mode <= 7) begin
				len = $urandom_range(1, 12);
				op  = OP_REDO;
			end else if (mode == 8) begin
				len = $urandom_range(1, 10);
				op  = OP_PUSH;
			end else begin
				len = 1;
				op  = OP_CLEAR;
			end
			// The last burst is cut so the phase sends exactly its share.
			if (len > n_items - issued)
				len = n_items - issued;
			for (int i = 0; i < len; i++) begin
				if (mode == 8)
					op = OP_W'($urandom_range(0, 3));
				issue(op, $urandom());
			end
			issued += len;
		end
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps[8];
		phase_caps = '{6'd32, 6'd1, 6'd63, 6'd3, 6'd0, 6'd17, 6'd20, 6'd32};
		phase_caps[6] = CAP_W'($urandom_range(0, 63));
		tracker     = new();
		cycles      = 0;
		idling      = 1'b1;
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = OP_PUSH;
		snapshot_in = '0;
		cfg_we      = 1'b0;
		cfg_data    = CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stacks, extreme words, a full undo/redo round trip at reset capacity.
		issue(OP_UNDO, 32'h1234_5678);
		issue(OP_REDO, 32'h9ABC_DEF0);
		issue(OP_PUSH, 32'h0000_0000);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_UNDO, 32'hA5A5_A5A5);
		issue(OP_REDO, 32'h5A5A_5A5A);
		issue(OP_UNDO, 32'h0F0F_0F0F);
		issue(OP_UNDO, 32'hF0F0_F0F0);
		issue(OP_UNDO, 32'hFFFF_FFFF);
		issue(OP_REDO, 32'h0000_0001);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_CLEAR, 32'hDEAD_BEEF);
		issue(OP_REDO, 32'h7FFF_FFFF);
		drain_results();

		// Capacity above the store depth, then lowered: undo does not trim, push does.
		write_capacity(6'd63);
		for (int i = 0; i < 4; i++)
			issue(OP_PUSH, $urandom());
		drain_results();
		write_capacity(6'd2);
		issue(OP_UNDO, $urandom());
		issue(OP_PUSH, $urandom());
		drain_results();

		// Capacity zero acts as one.
		write_capacity(6'd0);
		issue(OP_PUSH, $urandom());
		issue(OP_PUSH, $urandom());
		issue(OP_UNDO, $urandom());
		issue(OP_UNDO, $urandom());
		drain_results();

		// Random phases, each at its own capacity, with a full drain halfway through.
		for (int phase = 0; phase < 8; phase++) begin
			idling = (phase % 3) != 2;
			write_capacity(phase_caps[phase]);
			run_bursts(PHASE_ITEMS / 2);
			drain_results();
			run_bursts(PHASE_ITEMS / 2);
			drain_results();
		end

		if (tracker.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
src/urs_pkg.sv
src/urs_ram.sv
src/urs_ctrl.sv
src/bounded_undo_redo_stacks_top.sv
tb/bounded_undo_redo_stacks_top_tb.sv
